/* rtl/sitoa_pkg.sv */
`timescale 1ns / 1ps

package sitoa_pkg;

	localparam int MAG_W        = 32;
	localparam int NDIG         = 10;
	localparam int DIG_W        = 4;
	localparam int BCD_W        = NDIG * DIG_W;
	localparam int STEPS_STAGE  = 8;
	localparam int N_BCD_STAGES = MAG_W / STEPS_STAGE;
	localparam int IDX_W        = $clog2(NDIG);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
		logic [MAG_W-1:0] bin;
	} bcd_item_t;

	// shift-and-add-three over STEPS_STAGE bits of the binary word
	function automatic bcd_item_t dabble_steps(bcd_item_t d);
		bcd_item_t r;
		r = d;
		for (int s = 0; s < STEPS_STAGE; s++) begin
			for (int g = 0; g < NDIG; g++) begin
				if (r.bcd[g*DIG_W +: DIG_W] >= 4'd5)
					r.bcd[g*DIG_W +: DIG_W] = r.bcd[g*DIG_W +: DIG_W] + 4'd3;
			end
			{r.bcd, r.bin} = {r.bcd, r.bin} << 1;
		end
		return r;
	endfunction

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals                        Content
// s_        in         s_tvalid s_tready s_tdata      value (signed 32 bits)
// m_        out        m_tvalid m_tready m_tdata      char_code (8 bits)
//                      m_tlast                        last character of a value
//
// A value gives 1 to 11 characters, the length of its text; the character
// serializer at the end paces them and takes a new value as the last one goes.
// The first character passes through six registers: magnitude stage, four
// binary-to-BCD stages of eight bits each, then the serializer.
// arst_n clears all valid bits; payload registers are not reset.
// Stalls on m_ back up through the stages; nothing is lost or repeated.

module signed_int_to_decimal_ascii
	import sitoa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic signed [31:0] s_tdata,  // [31:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,  // [7:0] char_code
	output logic               m_tlast
);

	logic      valid_s1;
	bcd_item_t data_s1;
	logic      ready_s1;

	logic      st_valid [N_BCD_STAGES+1];
	logic      st_ready [N_BCD_STAGES+1];
	bcd_item_t st_data  [N_BCD_STAGES+1];

	// magnitude on 32 unsigned bits covers the most negative value
	assign s_tready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1.neg <= s_tdata[MAG_W-1];
			data_s1.bcd <= '0;
			data_s1.bin <= s_tdata[MAG_W-1] ? (~s_tdata + 32'd1) : s_tdata;
		end
	end

	assign st_valid[0] = valid_s1;
	assign st_data[0]  = data_s1;
	assign ready_s1    = st_ready[0];

	for (genvar g = 0; g < N_BCD_STAGES; g++) begin : g_bcd
		sitoa_bcd_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[g]),
			.in_ready  (st_ready[g]),
			.in_data   (st_data[g]),
			.out_valid (st_valid[g+1]),
			.out_ready (st_ready[g+1]),
			.out_data  (st_data[g+1])
		);
	end

	sitoa_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid[N_BCD_STAGES]),
		.in_ready  (st_ready[N_BCD_STAGES]),
		.in_data   (st_data[N_BCD_STAGES]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

/* rtl/sitoa_bcd_stage.sv */
`timescale 1ns / 1ps

module sitoa_bcd_stage
	import sitoa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bcd_item_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output bcd_item_t out_data
);

	logic      valid_s1;
	bcd_item_t data_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= dabble_steps(in_data);
		end
	end

endmodule

/* rtl/sitoa_ser.sv */
`timescale 1ns / 1ps

module sitoa_ser
	import sitoa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bcd_item_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	logic             valid_q;
	logic             neg_pend_q;
	logic [IDX_W-1:0] idx_q;
	logic [DIG_W-1:0] dig_q [NDIG];
	logic [IDX_W-1:0] top_dig;
	logic             take;

	// highest non-zero digit, zero gives digit 0
	always_comb begin
		top_dig = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (in_data.bcd[i*DIG_W +: DIG_W] != '0)
				top_dig = IDX_W'(i);
		end
	end

	assign out_valid = valid_q;
	assign out_last  = !neg_pend_q && (idx_q == '0);
	assign out_char  = neg_pend_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, dig_q[idx_q]});
	assign take      = out_valid && out_ready;
	assign in_ready  = !valid_q || (take && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			neg_pend_q <= 1'b0;
			idx_q      <= '0;
		end else if (in_ready) begin
			valid_q    <= in_valid;
			neg_pend_q <= in_valid && in_data.neg;
			idx_q      <= top_dig;
		end else if (take) begin
			// advance: drop the sign first, then step down the digits
			if (neg_pend_q)
				neg_pend_q <= 1'b0;
			else
				idx_q <= idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int i = 0; i < NDIG; i++)
				dig_q[i] <= in_data.bcd[i*DIG_W +: DIG_W];
		end
	end

endmodule

/* rtl/sitoa_chk.sv */
`timescale 1ns / 1ps

module sitoa_chk
	import sitoa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic signed [31:0] s_tdata,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [7:0]         m_tdata,
	input logic               m_tlast
);

	// hold a waiting request
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("waiting request changed");

	// hold a stalled character
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled character changed");

	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == CHAR_MINUS) ||
			(m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE))
		else $error("character outside sign and digits");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast)
		else $error("sign marked as last");

	// a sign is followed at once by a non-zero leading digit
	a_after_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata == CHAR_MINUS |=>
			m_tvalid && m_tdata >= CHAR_ONE && m_tdata <= CHAR_NINE)
		else $error("sign not followed by leading digit");

endmodule

bind signed_int_to_decimal_ascii sitoa_chk u_chk (.*);

/* tb/sitoa_checker.sv */
`timescale 1ns / 1ps

module sitoa_checker
	import sitoa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic signed [31:0] s_tdata,  // [31:0] value
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [7:0]         m_tdata,  // [7:0] char_code
	input  logic               m_tlast,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} text_char_t;

	text_char_t expected_text[$];

	// append the decimal text of one request, most significant character first
	function automatic void queue_text_of(input logic signed [31:0] value);
		logic [32:0] mag;
		logic [3:0]  digits [10];
		int          nd;
		text_char_t  c;
		mag = value[31] ? 33'd0 - {value[31], value} : {1'b0, value};
		nd  = 0;
		do begin
			digits[nd] = 4'(mag % 33'd10);
			mag        = mag / 33'd10;
			nd++;
		end while (mag != 33'd0);
		if (value[31]) begin
			c.char_code = CHAR_MINUS;
			c.last      = 1'b0;
			expected_text.push_back(c);
		end
		for (int j = nd - 1; j >= 0; j--) begin
			c.char_code = CHAR_ZERO + 8'(digits[j]);
			c.last      = (j == 0);
			expected_text.push_back(c);
		end
	endfunction

	always @(posedge clk) begin : watch
		text_char_t e;
		if (!arst_n) begin
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_text.size() == 0) begin
					$error("char_code: expected none, got %0d", m_tdata);
					fail_count++;
				end else begin
					e = expected_text.pop_front();
					if (m_tdata !== e.char_code) begin
						$error("char_code: expected %0d, got %0d", e.char_code, m_tdata);
						fail_count++;
					end
					if (m_tlast !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				queue_text_of(s_tdata);
			pending = expected_text.size();
		end
	end

endmodule

/* tb/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic signed [31:0] s_tdata;  // [31:0] value
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;  // [7:0] char_code
	logic               m_tlast;
	int                 fail_count;
	int                 pending;

	int send_idle_pct;
	int recv_stall_pct;

	signed_int_to_decimal_ascii u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sitoa_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	// hold the request until accepted; leave at a falling edge
	task automatic send_value(input logic signed [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// mostly a chosen digit count with random sign, sometimes any 32-bit word
	function automatic logic signed [31:0] random_value();
		logic [63:0] p10;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] m;
		int          nd;
		logic        neg;
		if ($urandom_range(3) == 0)
			return $urandom;
		nd  = $urandom_range(10, 1);
		p10 = 64'd1;
		repeat (nd - 1) p10 = p10 * 64'd10;
		lo  = (nd == 1) ? 64'd0 : p10;
		hi  = p10 * 64'd10 - 64'd1;
		if (hi > 64'd2147483648)
			hi = 64'd2147483648;
		m   = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
		neg = 1'($urandom_range(1));
		if (!neg && m > 64'd2147483647)
			m = 64'd2147483647;
		return neg ? 32'(64'd0 - m) : 32'(m);
	endfunction

	logic signed [31:0] directed [20] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
		32'sd2147483647, 32'sh80000000, -32'sd2147483647, 32'sd1000000000,
		-32'sd1000000000, 32'sd999999999, 32'sd1999999999, 32'sh55555555,
		32'shAAAAAAAA, 32'sd1234567890, -32'sd1234567890
	};

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_value(directed[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			repeat (100) send_value(random_value());
		end
		s_tvalid <= 1'b0;

		// drain, then allow for the pipeline latency
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
